// File: hdl/oaat_pkg.sv
// Shared types, constants and hash mix functions for the one-at-a-time bucket index block.
// No dependencies; every other file in hdl/ uses this package.
package oaat_pkg;

  localparam int HASH_W = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_W = $clog2(HASH_W);
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int OUT_TDATA_W = 2 * HASH_W;
  localparam logic [HASH_W-1:0] NUM_BUCKETS_RESET = HASH_W'(1024);

  typedef logic [HASH_W-1:0] hash_t;

  typedef struct packed {
    logic  valid;
    hash_t hash;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    hash_t hash;
  } q_rd_t;

  function automatic hash_t mix_byte(hash_t h_in, logic [BYTE_W-1:0] b);
    hash_t h;
    h = h_in + hash_t'(b);
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  function automatic hash_t finalize(hash_t h_in);
    hash_t h;
    h = h_in + (h_in << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

endpackage

// File: hdl/one_at_a_time_bucket_index.sv
// One-at-a-time bucket index: takes one key byte per cycle while in_tready is high and
// mixes it into a 32-bit running hash; on the last byte of a key the hash is queued,
// finalized and reduced modulo the bucket count by a bit-serial divider (one bit per cycle).
// The back end handles one key at a time and takes the next only after the last result has
// been loaded into the output register; a two-entry queue lets the next keys stream in
// meanwhile, so input stalls only when the queue is full, that is when short keys arrive
// back to back or when results are not taken. A bucket count of 0 gives bucket_index = hash_value.
// Write the bucket count only while no key is in flight. Depends on oaat_pkg and submodules.
module one_at_a_time_bucket_index (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [oaat_pkg::BYTE_W-1:0]       in_tdata,   // [7:0] key_byte
  input  logic                              in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [oaat_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [31:0] bucket_index, [63:32] hash_value
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [oaat_pkg::HASH_W-1:0]       cfg_data    // bucket count
);

  oaat_pkg::hash_t num_buckets_r, num_buckets_nxt;
  oaat_pkg::q_wr_t q_wr;
  oaat_pkg::q_rd_t q_rd;
  logic            q_full;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_buckets_nxt = num_buckets_r;
    if (cfg_valid && cfg_ready) begin
      num_buckets_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_buckets_r <= oaat_pkg::NUM_BUCKETS_RESET;
    end else begin
      num_buckets_r <= num_buckets_nxt;
    end
  end

  oaat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  oaat_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  oaat_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rd        (q_rd),
    .q_pop       (q_pop),
    .num_buckets (num_buckets_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// File: hdl/oaat_front.sv
// Front end: accepts key bytes, keeps the running hash, pushes each mixed key hash.
// Depends on oaat_pkg.
module oaat_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [oaat_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] key_byte
  input  logic                         in_tlast,   // last_byte
  input  logic                         q_full,
  output oaat_pkg::q_wr_t              q_wr
);

  oaat_pkg::hash_t run_hash_r;
  oaat_pkg::hash_t run_hash_nxt;
  oaat_pkg::hash_t mixed;
  logic            acc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign mixed     = oaat_pkg::mix_byte(run_hash_r, in_tdata);

  assign q_wr.valid = acc && in_tlast;
  assign q_wr.hash  = mixed;

  always_comb begin
    run_hash_nxt = run_hash_r;
    if (acc) begin
      run_hash_nxt = in_tlast ? '0 : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_hash_r <= '0;
    end else begin
      run_hash_r <= run_hash_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (run_hash_r == '0))
    else $error("running hash not cleared after last byte");
`endif

endmodule

// File: hdl/oaat_fifo.sv
// Short queue of mixed key hashes between front and back.
// Depends on oaat_pkg.
module oaat_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  oaat_pkg::q_wr_t q_wr,
  output logic            q_full,
  output oaat_pkg::q_rd_t q_rd,
  input  logic            q_pop
);

  oaat_pkg::hash_t                mem_r [oaat_pkg::Q_DEPTH];
  logic [oaat_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [oaat_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [oaat_pkg::Q_AW:0]        cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign q_full     = (cnt_r == (oaat_pkg::Q_AW+1)'(oaat_pkg::Q_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.hash  = mem_r[rd_ptr_r];
  assign do_push    = q_wr.valid && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == oaat_pkg::Q_AW'(oaat_pkg::Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == oaat_pkg::Q_AW'(oaat_pkg::Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.hash;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.valid |-> !q_full)
    else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (oaat_pkg::Q_AW+1)'(oaat_pkg::Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// File: hdl/oaat_back.sv
// Back end: final mix, bit-serial modulo by the bucket count, registered result output.
// Depends on oaat_pkg.
module oaat_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  oaat_pkg::q_rd_t                   q_rd,
  output logic                              q_pop,
  input  oaat_pkg::hash_t                   num_buckets,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [oaat_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIN,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  oaat_pkg::hash_t            hash_r, hash_nxt;
  oaat_pkg::hash_t            quo_r, quo_nxt;
  oaat_pkg::hash_t            rem_r, rem_nxt;
  oaat_pkg::hash_t            div_r, div_nxt;
  logic [oaat_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  oaat_pkg::hash_t            out_idx_r, out_idx_nxt;
  oaat_pkg::hash_t            out_hash_r, out_hash_nxt;
  logic [oaat_pkg::HASH_W:0]  trial;
  oaat_pkg::hash_t            fin;
  oaat_pkg::hash_t            rem_fin;
  logic                       load_out;

  assign fin      = oaat_pkg::finalize(hash_r);
  assign trial    = {rem_r, quo_r[oaat_pkg::HASH_W-1]};
  assign rem_fin  = (div_r == '0) ? hash_r : rem_r;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign q_pop    = (state_r == ST_IDLE) && q_rd.valid;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hash_r, out_idx_r};

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_hash_nxt  = out_hash_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_rd.valid) begin
          hash_nxt  = q_rd.hash;
          div_nxt   = num_buckets;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        hash_nxt  = fin;
        quo_nxt   = fin;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = oaat_pkg::HASH_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[oaat_pkg::HASH_W-1:0];
        end
        quo_nxt = quo_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == oaat_pkg::CNT_W'(oaat_pkg::HASH_W-1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = rem_fin;
          out_hash_nxt  = hash_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hash_r     <= hash_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    out_idx_r  <= out_idx_nxt;
    out_hash_r <= out_hash_nxt;
  end

`ifndef ASSERT_OFF
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && div_r != '0) |-> (rem_fin < div_r))
    else $error("bucket index not below bucket count");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_FIN))
    else $error("pop did not start a key");
`endif

endmodule
